// ----- hw/rtl/marker_length_frame_deframer_core_defines.svh -----
// assertion macros for the marker length frame deframer
// needs a clock named clock and a reset named reset in the module that uses them
`ifndef MARKER_LENGTH_FRAME_DEFRAMER_CORE_DEFINES_SVH
`define MARKER_LENGTH_FRAME_DEFRAMER_CORE_DEFINES_SVH

// same-cycle implication
`define MLFD_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mlfd assertion failed");

// next-cycle implication
`define MLFD_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mlfd assertion failed");

`endif

// ----- hw/rtl/mlfd_pkg.sv -----
// shared types and constants of the marker length frame deframer
// no dependencies
package mlfd_pkg;

   localparam logic [7:0] CR = 8'h0D;
   localparam logic [7:0] LF = 8'h0A;
   localparam logic [15:0] JPEG_SOI = 16'hFFD8;
   localparam logic [15:0] JPEG_EOI = 16'hFFD9;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_BAD_START = 3'd1;
   localparam logic [2:0] ST_BAD_END   = 3'd2;
   localparam logic [2:0] ST_NOT_IMAGE = 3'd3;
   localparam logic [2:0] ST_OVERSIZE  = 3'd4;
   localparam logic [2:0] ST_ABORTED   = 3'd5;

   localparam int CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_TYPE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_LEN    = 2'd1;

   localparam logic [31:0] MAX_LEN_RESET = 32'd4000000;

   // one classified byte: the byte and whether it completes a marker
   typedef struct packed {
      logic [7:0] data;
      logic       marker;
   } entry_type;

endpackage

// ----- hw/rtl/mlfd_front.sv -----
// front end: accepts link bytes and tracks the CR LF CR LF marker
// depends on mlfd_pkg
module mlfd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [7:0]          req_in_byte,
   output logic                req_stall,
   input  logic                q_full,
   output logic                push,
   output mlfd_pkg::entry_type entry
);

   logic [1:0] marker_ff;
   logic [1:0] marker_in;
   logic [7:0] want;
   logic       done;

   assign req_stall = q_full;
   assign push      = req_valid && !q_full;

   always_comb begin
      want      = (marker_ff == 2'd0 || marker_ff == 2'd2) ? mlfd_pkg::CR : mlfd_pkg::LF;
      done      = 1'b0;
      marker_in = marker_ff;
      if (push) begin
         if (req_in_byte == want) begin
            if (marker_ff == 2'd3) begin
               done      = 1'b1;
               // trailing cr lf starts the next marker
               marker_in = 2'd2;
            end else begin
               marker_in = marker_ff + 2'd1;
            end
         end else begin
            marker_in = (req_in_byte == mlfd_pkg::CR) ? 2'd1 : 2'd0;
         end
      end
   end

   assign entry.data   = req_in_byte;
   assign entry.marker = done;

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff <= 2'd0;
      end else begin
         marker_ff <= marker_in;
      end
   end

endmodule

// ----- hw/rtl/mlfd_queue.sv -----
// short queue of classified bytes between front and back
// depends on mlfd_pkg and the assertion macro header
`include "marker_length_frame_deframer_core_defines.svh"
module mlfd_queue #(
   parameter int DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mlfd_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                q_valid,
   output mlfd_pkg::entry_type head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   mlfd_pkg::entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;

   assign full    = (count_ff == FULL_CNT);
   assign q_valid = (count_ff != '0);
   assign head    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   `MLFD_ASSERT_NOW(a_count_bound, 1'b1, count_ff <= FULL_CNT)
   `MLFD_ASSERT_NEXT(a_count_grows, push && !pop, count_ff == $past(count_ff) + 1'b1)
   `MLFD_ASSERT_NOW(a_no_pop_empty, pop, q_valid)

endmodule

// ----- hw/rtl/mlfd_back.sv -----
// back end: header parse, payload pass-through, frame status and result register
// depends on mlfd_pkg and the assertion macro header
`include "marker_length_frame_deframer_core_defines.svh"
module mlfd_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write,
   input  logic [mlfd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [31:0]                          csr_wdata,
   input  logic                                 q_valid,
   input  mlfd_pkg::entry_type                  head,
   output logic                                 pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [7:0]                           rsp_out_byte,
   output logic                                 rsp_byte_valid,
   output logic [31:0]                          rsp_frame_kind,
   output logic                                 rsp_end_of_frame,
   output logic [2:0]                           rsp_frame_status
);

   localparam logic [1:0] PH_HUNT = 2'd0;
   localparam logic [1:0] PH_TYPE = 2'd1;
   localparam logic [1:0] PH_LEN  = 2'd2;
   localparam logic [1:0] PH_DATA = 2'd3;

   logic [31:0] image_type_ff;
   logic [31:0] max_len_ff;

   logic [1:0]  phase_ff, phase_in;
   logic [1:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [31:0] kind_ff, kind_in;
   logic [31:0] len_ff, len_in;
   logic [31:0] left_ff, left_in;
   logic        start_ok_ff, start_ok_in;
   logic [15:0] last_ff, last_in;
   logic [1:0]  pos_ff, pos_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [7:0]  out_byte_ff;
   logic        byte_valid_ff;
   logic [31:0] kind_out_ff;
   logic        end_ff;
   logic [2:0]  status_ff;

   logic        can_load;
   logic        emit;
   logic [7:0]  e_byte;
   logic        e_valid;
   logic        e_end;
   logic [2:0]  e_status;
   logic [7:0]  b;
   logic [15:0] new_last;
   logic        new_start;
   logic [31:0] full_len;
   logic [31:0] lane;

   assign can_load = !rsp_valid_ff || !rsp_stall;
   assign pop      = q_valid && can_load;
   assign b        = head.data;
   assign new_last = {last_ff[7:0], b};
   assign lane     = {24'd0, b} << {hdr_cnt_ff, 3'b000};
   assign full_len = len_ff | {b, 24'd0};

   always_comb begin
      phase_in    = phase_ff;
      hdr_cnt_in  = hdr_cnt_ff;
      kind_in     = kind_ff;
      len_in      = len_ff;
      left_in     = left_ff;
      start_ok_in = start_ok_ff;
      last_in     = last_ff;
      pos_in      = pos_ff;
      emit        = 1'b0;
      e_byte      = 8'd0;
      e_valid     = 1'b0;
      e_end       = 1'b0;
      e_status    = mlfd_pkg::ST_OK;
      new_start   = start_ok_ff;
      if (pop) begin
         if (head.marker) begin
            if (phase_ff == PH_DATA) begin
               emit     = 1'b1;
               e_end    = 1'b1;
               e_status = mlfd_pkg::ST_ABORTED;
            end
            phase_in   = PH_TYPE;
            hdr_cnt_in = 2'd0;
            kind_in    = 32'd0;
            len_in     = 32'd0;
         end else begin
            unique case (phase_ff)
               PH_HUNT: begin
               end
               PH_TYPE: begin
                  kind_in = kind_ff | lane;
                  if (hdr_cnt_ff == 2'd3) begin
                     phase_in   = PH_LEN;
                     hdr_cnt_in = 2'd0;
                  end else begin
                     hdr_cnt_in = hdr_cnt_ff + 2'd1;
                  end
               end
               PH_LEN: begin
                  len_in = len_ff | lane;
                  if (hdr_cnt_ff != 2'd3) begin
                     hdr_cnt_in = hdr_cnt_ff + 2'd1;
                  end else begin
                     hdr_cnt_in  = 2'd0;
                     start_ok_in = 1'b0;
                     last_in     = 16'd0;
                     if (full_len > max_len_ff) begin
                        phase_in = PH_HUNT;
                        emit     = 1'b1;
                        e_end    = 1'b1;
                        e_status = mlfd_pkg::ST_OVERSIZE;
                     end else if (full_len == 32'd0) begin
                        phase_in = PH_HUNT;
                        emit     = 1'b1;
                        e_end    = 1'b1;
                        e_status = (kind_ff != image_type_ff) ? mlfd_pkg::ST_NOT_IMAGE
                                                              : mlfd_pkg::ST_BAD_START;
                     end else begin
                        left_in  = full_len;
                        pos_in   = 2'd0;
                        phase_in = PH_DATA;
                     end
                  end
               end
               PH_DATA: begin
                  last_in = new_last;
                  if (pos_ff == 2'd1) begin
                     new_start = (new_last == mlfd_pkg::JPEG_SOI);
                  end
                  start_ok_in = new_start;
                  pos_in      = (pos_ff == 2'd2) ? 2'd2 : pos_ff + 2'd1;
                  left_in     = left_ff - 32'd1;
                  emit        = 1'b1;
                  e_byte      = b;
                  e_valid     = 1'b1;
                  if (left_ff == 32'd1) begin
                     phase_in = PH_HUNT;
                     e_end    = 1'b1;
                     if (kind_ff != image_type_ff) begin
                        e_status = mlfd_pkg::ST_NOT_IMAGE;
                     end else if (!new_start) begin
                        e_status = mlfd_pkg::ST_BAD_START;
                     end else if (new_last != mlfd_pkg::JPEG_EOI) begin
                        e_status = mlfd_pkg::ST_BAD_END;
                     end else begin
                        e_status = mlfd_pkg::ST_OK;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
      end
      rsp_valid_in = can_load ? (pop && emit) : rsp_valid_ff;
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         image_type_ff <= 32'd0;
         max_len_ff    <= mlfd_pkg::MAX_LEN_RESET;
      end else if (csr_write) begin
         case (csr_index)
            mlfd_pkg::CSR_IMAGE_TYPE: image_type_ff <= csr_wdata;
            mlfd_pkg::CSR_MAX_LEN:    max_len_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HUNT;
         hdr_cnt_ff   <= 2'd0;
         kind_ff      <= 32'd0;
         len_ff       <= 32'd0;
         left_ff      <= 32'd0;
         start_ok_ff  <= 1'b0;
         last_ff      <= 16'd0;
         pos_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         hdr_cnt_ff   <= hdr_cnt_in;
         kind_ff      <= kind_in;
         len_ff       <= len_in;
         left_ff      <= left_in;
         start_ok_ff  <= start_ok_in;
         last_ff      <= last_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result register payload
   always_ff @(posedge clock) begin
      if (pop && emit) begin
         out_byte_ff   <= e_byte;
         byte_valid_ff <= e_valid;
         kind_out_ff   <= kind_ff;
         end_ff        <= e_end;
         status_ff     <= e_status;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_byte_valid   = byte_valid_ff;
   assign rsp_frame_kind   = kind_out_ff;
   assign rsp_end_of_frame = end_ff;
   assign rsp_frame_status = status_ff;

   `MLFD_ASSERT_NOW(a_empty_needs_end, rsp_valid_ff && !byte_valid_ff, end_ff)
   `MLFD_ASSERT_NOW(a_status_only_at_end, rsp_valid_ff && !end_ff, status_ff == mlfd_pkg::ST_OK)
   `MLFD_ASSERT_NEXT(a_abort_emits, pop && head.marker && phase_ff == PH_DATA,
                     rsp_valid_ff && end_ff && status_ff == mlfd_pkg::ST_ABORTED)

endmodule

// ----- hw/rtl/marker_length_frame_deframer_core.sv -----
// marker length frame deframer, top level
// depends on mlfd_pkg, mlfd_front, mlfd_queue and mlfd_back
//
// usage: link bytes enter on the req_ channel, one item per byte. the block hunts
// for CR LF CR LF, reads a little-endian type word and length word, then passes
// the payload out on the rsp_ channel; the last payload item carries end_of_frame
// and the frame status. a marker inside a payload closes the frame as aborted, and
// a zero or oversize length closes it, each with an item that has no byte. other
// header bytes and markers give no item. csr_ writes set the image type code
// (index 0) and the payload limit (index 1); write only while the block is idle.
// throughput: one byte per cycle when rsp_ is not stalled, set by the back-end step.
// a byte is written into the queue, then popped by the back end into the result
// register that drives rsp_; bytes queued ahead of it are popped first.
// the front stalls req_ only when the QUEUE_DEPTH-entry queue is full; a stall
// on rsp_ holds the result register, and the queue absorbs QUEUE_DEPTH more bytes.
// reset (synchronous) empties the queue, clears the result valid flag, restarts
// the marker hunt and restores the register defaults.
module marker_length_frame_deframer_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_in_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [7:0]                           rsp_out_byte,
   output logic                                 rsp_byte_valid,
   output logic [31:0]                          rsp_frame_kind,
   output logic                                 rsp_end_of_frame,
   output logic [2:0]                           rsp_frame_status,
   input  logic                                 csr_write,
   input  logic [mlfd_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [31:0]                          csr_wdata
);

   logic                push;
   logic                q_full;
   logic                q_valid;
   logic                pop;
   mlfd_pkg::entry_type push_entry;
   mlfd_pkg::entry_type head;

   mlfd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_in_byte (req_in_byte),
      .req_stall   (req_stall),
      .q_full      (q_full),
      .push        (push),
      .entry       (push_entry)
   );

   mlfd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .q_valid    (q_valid),
      .head       (head)
   );

   mlfd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .q_valid          (q_valid),
      .head             (head),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_frame_kind   (rsp_frame_kind),
      .rsp_end_of_frame (rsp_end_of_frame),
      .rsp_frame_status (rsp_frame_status)
   );

endmodule

// ----- sim/marker_length_frame_deframer_core_tb.sv -----
// testbench for marker_length_frame_deframer_core: byte stream in, deframed items out
// a scoreboard class predicts every item from the accepted bytes and the register writes
// depends on mlfd_pkg and the marker_length_frame_deframer_core rtl
`timescale 1ns / 1ps

module marker_length_frame_deframer_core_tb;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned SETTLE_CYCLES = 16;
   localparam logic [mlfd_pkg::CSR_INDEX_W-1:0] CSR_SPARE_LO = 2'd2;
   localparam logic [mlfd_pkg::CSR_INDEX_W-1:0] CSR_SPARE_HI = 2'd3;

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_KIND,
      PH_LEN,
      PH_PAYLOAD
   } deframe_phase_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        has_byte;
      logic [31:0] kind;
      logic        eof;
      logic [2:0]  status;
   } deframed_item_type;

   class deframe_scoreboard;
      logic [31:0] image_code;
      logic [31:0] len_limit;
      deframe_phase_type phase;
      logic [2:0] mark_cnt;
      logic [1:0] hdr_cnt;
      logic [31:0] kind;
      logic [31:0] len;
      logic [31:0] left;
      logic start_good;
      logic [15:0] tail;
      deframed_item_type deframed_due[$];
      int unsigned mismatches;
      int unsigned checked;

      function new();
         image_code = 32'd0;
         len_limit = mlfd_pkg::MAX_LEN_RESET;
         phase = PH_HUNT;
         mark_cnt = 3'd0;
         hdr_cnt = 2'd0;
         kind = 32'd0;
         len = 32'd0;
         left = 32'd0;
         start_good = 1'b0;
         tail = 16'd0;
         mismatches = 0;
         checked = 0;
      endfunction

      function void write_reg(logic [mlfd_pkg::CSR_INDEX_W-1:0] idx, logic [31:0] data);
         if (idx == mlfd_pkg::CSR_IMAGE_TYPE) image_code = data;
         else if (idx == mlfd_pkg::CSR_MAX_LEN) len_limit = data;
      endfunction

      function bit marker_step(logic [7:0] b);
         logic [7:0] want;
         bit done;
         done = 0;
         want = (mark_cnt == 3'd0 || mark_cnt == 3'd2) ? mlfd_pkg::CR : mlfd_pkg::LF;
         if (b == want) begin
            mark_cnt = mark_cnt + 3'd1;
            if (mark_cnt == 3'd4) begin
               done = 1;
               mark_cnt = 3'd2;
            end
         end else begin
            mark_cnt = (b == mlfd_pkg::CR) ? 3'd1 : 3'd0;
         end
         return done;
      endfunction

      function logic [2:0] close_status();
         if (kind != image_code) return mlfd_pkg::ST_NOT_IMAGE;
         if (!start_good) return mlfd_pkg::ST_BAD_START;
         if (tail != mlfd_pkg::JPEG_EOI) return mlfd_pkg::ST_BAD_END;
         return mlfd_pkg::ST_OK;
      endfunction

      function void push_item(logic [7:0] b, logic has_b, logic eof, logic [2:0] st);
         deframed_item_type it;
         it.data_byte = b;
         it.has_byte = has_b;
         it.kind = kind;
         it.eof = eof;
         it.status = st;
         deframed_due = {deframed_due, it};
      endfunction

      function void deframe_byte(logic [7:0] b);
         logic [31:0] pos;
         if (marker_step(b)) begin
            if (phase == PH_PAYLOAD) push_item(8'h00, 1'b0, 1'b1, mlfd_pkg::ST_ABORTED);
            phase = PH_KIND;
            hdr_cnt = 2'd0;
            kind = 32'd0;
            len = 32'd0;
            return;
         end
         case (phase)
            PH_KIND: begin
               kind = kind | (32'(b) << (8 * hdr_cnt));
               if (hdr_cnt == 2'd3) begin
                  phase = PH_LEN;
                  hdr_cnt = 2'd0;
               end else begin
                  hdr_cnt = hdr_cnt + 2'd1;
               end
            end
            PH_LEN: begin
               len = len | (32'(b) << (8 * hdr_cnt));
               if (hdr_cnt != 2'd3) begin
                  hdr_cnt = hdr_cnt + 2'd1;
               end else begin
                  hdr_cnt = 2'd0;
                  start_good = 1'b0;
                  tail = 16'd0;
                  if (len > len_limit) begin
                     phase = PH_HUNT;
                     push_item(8'h00, 1'b0, 1'b1, mlfd_pkg::ST_OVERSIZE);
                  end else if (len == 32'd0) begin
                     phase = PH_HUNT;
                     push_item(8'h00, 1'b0, 1'b1, close_status());
                  end else begin
                     left = len;
                     phase = PH_PAYLOAD;
                  end
               end
            end
            PH_PAYLOAD: begin
               pos = len - left;
               tail = {tail[7:0], b};
               if (pos == 32'd1) start_good = (tail == mlfd_pkg::JPEG_SOI);
               left = left - 32'd1;
               if (left == 32'd0) begin
                  phase = PH_HUNT;
                  push_item(b, 1'b1, 1'b1, close_status());
               end else begin
                  push_item(b, 1'b1, 1'b0, mlfd_pkg::ST_OK);
               end
            end
            default: ;
         endcase
      endfunction

      function void report(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%s", msg);
      endfunction

      function void check_result(deframed_item_type got);
         deframed_item_type want;
         checked++;
         if (deframed_due.size() == 0) begin
            report($sformatf("item %0d unexpected: byte %h valid %b kind %h eof %b status %0d",
               checked, got.data_byte, got.has_byte, got.kind, got.eof, got.status));
            return;
         end
         want = deframed_due[0];
         deframed_due.delete(0);
         if (got.data_byte !== want.data_byte || got.has_byte !== want.has_byte ||
             got.kind !== want.kind || got.eof !== want.eof || got.status !== want.status)
            report($sformatf({"item %0d expected byte %h valid %b kind %h eof %b status %0d,",
               " got byte %h valid %b kind %h eof %b status %0d"}, checked,
               want.data_byte, want.has_byte, want.kind, want.eof, want.status,
               got.data_byte, got.has_byte, got.kind, got.eof, got.status));
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [7:0] rsp_out_byte;
   logic rsp_byte_valid;
   logic [31:0] rsp_frame_kind;
   logic rsp_end_of_frame;
   logic [2:0] rsp_frame_status;
   logic csr_write = 1'b0;
   logic [mlfd_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [31:0] csr_wdata = 32'd0;

   deframe_scoreboard sb;
   bit quiet = 0;
   int unsigned bytes_sent = 0;
   int unsigned cycle_count = 0;

   marker_length_frame_deframer_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_frame_kind   (rsp_frame_kind),
      .rsp_end_of_frame (rsp_end_of_frame),
      .rsp_frame_status (rsp_frame_status),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("marker_length_frame_deframer_core: mismatch");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write) sb.write_reg(csr_index, csr_wdata);
         if (req_valid && !req_stall) sb.deframe_byte(req_in_byte);
         if (rsp_valid && !rsp_stall)
            sb.check_result(deframed_item_type'{rsp_out_byte, rsp_byte_valid, rsp_frame_kind,
               rsp_end_of_frame, rsp_frame_status});
      end
   end

   always @(negedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < 21);
   end

   function automatic logic [7:0] link_byte();
      case ($urandom_range(0, 9))
         0: return mlfd_pkg::CR;
         1: return mlfd_pkg::LF;
         2: return mlfd_pkg::JPEG_SOI[15:8];
         3: return mlfd_pkg::JPEG_SOI[7:0];
         4: return mlfd_pkg::JPEG_EOI[7:0];
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] b);
      while (!quiet && $urandom_range(0, 99) < 21) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_word(input logic [31:0] w);
      for (int i = 0; i < 4; i++) send_byte(w[8*i +: 8]);
   endtask

   task automatic send_marker();
      send_byte(mlfd_pkg::CR);
      send_byte(mlfd_pkg::LF);
      send_byte(mlfd_pkg::CR);
      send_byte(mlfd_pkg::LF);
   endtask

   task automatic write_reg(input logic [mlfd_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [31:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   // lets every byte drain out, including header bytes that give no item
   task automatic finish_phase();
      req_valid <= 1'b0;
      while (sb.deframed_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic send_random_frame();
      int unsigned mode;
      int unsigned n;
      logic [31:0] kind;
      logic [31:0] len;
      logic [31:0] limit;
      logic [7:0] body[$];
      limit = sb.len_limit;
      mode = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 4)) send_byte(link_byte());
      // overlapping markers
      if ($urandom_range(0, 9) == 0) begin
         send_byte(mlfd_pkg::CR);
         send_byte(mlfd_pkg::LF);
      end
      send_marker();
      kind = ($urandom_range(0, 99) < 60) ? sb.image_code : $urandom;
      // header cut short by the next marker
      if (mode < 10) begin
         repeat ($urandom_range(0, 7)) send_byte(link_byte());
         return;
      end
      send_word(kind);
      if (mode < 20 && limit != 32'hFFFF_FFFF) begin
         send_word($urandom_range(32'hFFFF_FFFF, limit + 32'd1));
         return;
      end
      if (mode < 28) begin
         send_word(32'd0);
         return;
      end
      // payload cut short by the next marker
      if (mode < 40) begin
         len = $urandom_range(limit, 1);
         n = (len > 32'd12) ? 12 : len - 32'd1;
         n = $urandom_range(n, 0);
         send_word(len);
         repeat (n) send_byte(link_byte());
         return;
      end
      if (limit <= 32'd40 && $urandom_range(0, 3) == 0) len = limit;
      else len = $urandom_range((limit < 32'd12) ? limit : 32'd12, 1);
      for (int i = 0; i < len; i++) body = {body, link_byte()};
      if (kind == sb.image_code && $urandom_range(0, 99) < 75) begin
         body[0] = mlfd_pkg::JPEG_SOI[15:8];
         if (len > 32'd1) body[1] = mlfd_pkg::JPEG_SOI[7:0];
      end
      if (kind == sb.image_code && $urandom_range(0, 99) < 75) begin
         body[len-1] = mlfd_pkg::JPEG_EOI[7:0];
         if (len > 32'd1) body[len-2] = mlfd_pkg::JPEG_EOI[15:8];
      end
      send_word(len);
      foreach (body[i]) send_byte(body[i]);
   endtask

   task automatic random_frames(input int unsigned items);
      int unsigned stop;
      stop = bytes_sent + items;
      while (bytes_sent < stop) send_random_frame();
   endtask

   task automatic run_phase(input logic [31:0] code, input logic [31:0] limit,
                            input int unsigned items);
      write_reg(mlfd_pkg::CSR_IMAGE_TYPE, code);
      write_reg(mlfd_pkg::CSR_MAX_LEN, limit);
      write_reg(CSR_SPARE_LO, $urandom);
      write_reg(CSR_SPARE_HI, $urandom);
      random_frames(items);
      finish_phase();
   endtask

   initial begin
      sb = new();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // byte extremes, a clean image frame, then a frame header at the length limit
      send_byte(8'h00);
      send_byte(8'hFF);
      send_marker();
      send_word(32'd0);
      send_word(32'd4);
      send_byte(mlfd_pkg::JPEG_SOI[15:8]);
      send_byte(mlfd_pkg::JPEG_SOI[7:0]);
      send_byte(mlfd_pkg::JPEG_EOI[15:8]);
      send_byte(mlfd_pkg::JPEG_EOI[7:0]);
      send_marker();
      send_word(32'hFFFF_FFFF);
      send_word(mlfd_pkg::MAX_LEN_RESET);

      random_frames(200);
      finish_phase();
      run_phase(32'hFFFF_FFFF, 32'hFFFF_FFFF, 180);
      run_phase($urandom, 32'd1, 180);
      quiet = 1;
      run_phase(32'd0, 32'd12, 180);
      quiet = 0;
      run_phase($urandom, 32'd3, 180);
      run_phase($urandom, $urandom_range(5000, 13), 180);

      if (sb.mismatches == 0 && sb.deframed_due.size() == 0)
         $display("marker_length_frame_deframer_core: match");
      else
         $display("marker_length_frame_deframer_core: mismatch");
      $finish;
   end

endmodule
